// File: hdl/cle_pkg.sv
// types, constants and index helpers shared by the console line editor
`timescale 1ns / 1ps

package cle_pkg;

	// ring geometry
	localparam int RING_DEPTH = 128;
	localparam int IDX_W      = $clog2(2 * RING_DEPTH);
	localparam int SLOT_W     = $clog2(RING_DEPTH);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [7:0]        char_t;

	localparam logic [IDX_W:0] IDX_SPAN  = (IDX_W + 1)'(2 * RING_DEPTH);
	localparam idx_t           DEPTH_IDX = IDX_W'(RING_DEPTH);

	// item opcodes
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// key codes
	localparam char_t KEY_NUL    = 8'h00;
	localparam char_t KEY_CTRL_D = 8'h04;
	localparam char_t KEY_CTRL_H = 8'h08;
	localparam char_t KEY_LF     = 8'h0A;
	localparam char_t KEY_CR     = 8'h0D;
	localparam char_t KEY_CTRL_P = 8'h10;
	localparam char_t KEY_CTRL_U = 8'h15;
	localparam char_t KEY_DEL    = 8'h7F;

	localparam char_t ERASE_MAX = 8'hFF;

	// input item
	typedef struct packed {
		logic  opcode;
		char_t key_code;
		logic  read_started;
	} cle_in_t;

	// result item
	typedef struct packed {
		logic  echo_valid;
		char_t echo_byte;
		char_t erase_count;
		logic  line_committed;
		logic  dump_request;
		logic  read_valid;
		char_t read_byte;
		logic  read_eof;
		logic  buffer_empty;
		logic  line_end;
	} cle_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec;
		logic ram_rd;
		logic kill_step;
		logic read_take;
		logic load_res;
	} cle_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic is_kill;
		logic read_pend;
		logic edit_at_commit;
		logic rd_is_lf;
	} cle_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_KILL_RD,
		ST_KILL_CHK,
		ST_READ_CHK,
		ST_FINISH
	} cle_state_t;

	// index arithmetic modulo twice the ring depth
	function automatic idx_t idx_inc(idx_t i);
		logic [IDX_W:0] n;
		n = {1'b0, i} + (IDX_W + 1)'(1);
		return (n >= IDX_SPAN) ? '0 : n[IDX_W-1:0];
	endfunction

	function automatic idx_t idx_dec(idx_t i);
		logic [IDX_W:0] top;
		top = IDX_SPAN - (IDX_W + 1)'(1);
		return (i == '0) ? top[IDX_W-1:0] : i - idx_t'(1);
	endfunction

	function automatic slot_t idx_slot(idx_t i);
		idx_t s;
		s = (i >= DEPTH_IDX) ? i - DEPTH_IDX : i;
		return s[SLOT_W-1:0];
	endfunction

	function automatic idx_t idx_diff(idx_t a, idx_t b);
		logic [IDX_W:0] w;
		w = {1'b0, a} + IDX_SPAN - {1'b0, b};
		return (a >= b) ? a - b : w[IDX_W-1:0];
	endfunction

endpackage

// File: hdl/cle_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/cle_ctrl.sv
// sequencing state machine of the console line editor
`timescale 1ns / 1ps

module cle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  cle_pkg::cle_sts_t sts,
	output cle_pkg::cle_ctl_t ctl
);

	import cle_pkg::*;

	cle_state_t state_q, state_d;
	logic       res_valid_q, res_valid_d;
	logic       res_free;

	// result register can take a new item
	assign res_free = !res_valid_q || !res_stall;

	// state and output flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_kill) begin
					state_d = ST_KILL_RD;
				end else if (sts.read_pend) begin
					ctl.ram_rd = 1'b1;
					state_d    = ST_READ_CHK;
				end else begin
					ctl.exec = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_KILL_RD: begin
				if (sts.edit_at_commit) begin
					state_d = ST_FINISH;
				end else begin
					ctl.ram_rd = 1'b1;
					state_d    = ST_KILL_CHK;
				end
			end
			ST_KILL_CHK: begin
				if (sts.rd_is_lf) begin
					state_d = ST_FINISH;
				end else begin
					ctl.kill_step = 1'b1;
					state_d       = ST_KILL_RD;
				end
			end
			ST_READ_CHK: begin
				ctl.read_take = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (res_free) begin
					ctl.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid holds until the item is taken
	always_comb begin
		res_valid_d = res_valid_q && res_stall;
		if (ctl.load_res) begin
			res_valid_d = 1'b1;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

// File: hdl/cle_dp.sv
// ring, indices and result registers of the console line editor
`timescale 1ns / 1ps

module cle_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cle_pkg::cle_in_t  cmd,
	input  cle_pkg::cle_ctl_t ctl,
	output cle_pkg::cle_sts_t sts,
	output cle_pkg::cle_out_t res
);

	import cle_pkg::*;

	cle_in_t  item_q;
	cle_out_t work_q, work_d;
	cle_out_t res_q;
	idx_t     read_q, read_d;
	idx_t     commit_q, commit_d;
	idx_t     edit_q, edit_d;

	logic     ram_we;
	slot_t    ram_waddr;
	slot_t    ram_raddr;
	char_t    ram_rdata;

	char_t    key;
	char_t    store_c;
	idx_t     edit_inc;
	logic     is_erase;
	logic     is_plain;
	logic     room;
	logic     commit_now;

	// key decode
	assign key        = item_q.key_code;
	assign store_c    = (key == KEY_CR) ? KEY_LF : key;
	assign edit_inc   = idx_inc(edit_q);
	assign is_erase   = (key == KEY_CTRL_H) || (key == KEY_DEL);
	assign is_plain   = (key != KEY_CTRL_P) && (key != KEY_CTRL_U) && !is_erase &&
	                    (key != KEY_NUL);
	assign room       = idx_diff(edit_q, read_q) < DEPTH_IDX;
	assign commit_now = (store_c == KEY_LF) || (store_c == KEY_CTRL_D) ||
	                    (idx_diff(edit_inc, read_q) == DEPTH_IDX);

	// ring addressing: reads look at the read index, kills at the byte before edit
	assign ram_waddr = idx_slot(edit_q);
	assign ram_raddr = (item_q.opcode == OP_READ) ? idx_slot(read_q) : idx_slot(idx_dec(edit_q));

	cle_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (store_c),
		.re    (ctl.ram_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// status for the controller
	always_comb begin
		sts.is_kill        = (item_q.opcode == OP_KEY) && (key == KEY_CTRL_U);
		sts.read_pend      = (item_q.opcode == OP_READ) && (read_q != commit_q);
		sts.edit_at_commit = (edit_q == commit_q);
		sts.rd_is_lf       = (ram_rdata == KEY_LF);
	end

	// item execution
	always_comb begin
		read_d   = read_q;
		commit_d = commit_q;
		edit_d   = edit_q;
		work_d   = work_q;
		ram_we   = 1'b0;

		if (ctl.load_item) begin
			work_d = '0;
		end

		// single step items
		if (ctl.exec) begin
			if (item_q.opcode == OP_READ) begin
				work_d.buffer_empty = 1'b1;
			end else if (key == KEY_CTRL_P) begin
				work_d.dump_request = 1'b1;
			end else if (is_erase) begin
				if (edit_q != commit_q) begin
					edit_d             = idx_dec(edit_q);
					work_d.erase_count = 8'd1;
				end
			end else if (is_plain && room) begin
				ram_we            = 1'b1;
				edit_d            = edit_inc;
				work_d.echo_valid = 1'b1;
				work_d.echo_byte  = store_c;
				if (commit_now) begin
					commit_d              = edit_inc;
					work_d.line_committed = 1'b1;
				end
			end
		end

		// kill line walks back one byte per pass
		if (ctl.kill_step) begin
			edit_d = idx_dec(edit_q);
			if (work_q.erase_count != ERASE_MAX) begin
				work_d.erase_count = work_q.erase_count + 8'd1;
			end
		end

		// committed byte taken by a read
		if (ctl.read_take) begin
			if (ram_rdata == KEY_CTRL_D) begin
				work_d.read_eof = 1'b1;
				if (!item_q.read_started) begin
					read_d = idx_inc(read_q);
				end
			end else begin
				read_d            = idx_inc(read_q);
				work_d.read_valid = 1'b1;
				work_d.read_byte  = ram_rdata;
				work_d.line_end   = (ram_rdata == KEY_LF);
			end
		end
	end

	// ring indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
		end else begin
			read_q   <= read_d;
			commit_q <= commit_d;
			edit_q   <= edit_d;
		end
	end

	// item, working result and output registers
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q <= cmd;
		end
		work_q <= work_d;
		if (ctl.load_res) begin
			res_q <= work_q;
		end
	end

	assign res = res_q;

endmodule

// File: hdl/console_line_editor_unit.sv
// top level of the console line editor
`timescale 1ns / 1ps

// Canonical-mode console input buffer. Key items (opcode 0) edit a ring of
// RING_DEPTH bytes held in one ram; read items (opcode 1) take one committed
// byte. Each item gives exactly one result item. One item is handled at a
// time: cmd_stall stays high from acceptance until the result is written to
// the output register, which then holds it under res_stall while the next
// item may already be accepted. A key item or a read of an empty ring
// passes through the execute and finish states, and a read that takes a
// byte adds a check state between them. Ctrl-U alternates ram read and
// check states, erasing one byte per pass through the ram's registered read
// port, until the walk reaches the committed line or a newline. The next
// item can be accepted in the cycle after the load, and a result still
// stalled in the output register delays the load until it is taken.

module console_line_editor_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cle_pkg::cle_in_t cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output cle_pkg::cle_out_t res
);

	import cle_pkg::*;

	cle_ctl_t ctl;
	cle_sts_t sts;

	// controller
	cle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// datapath
	cle_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.res    (res)
	);

endmodule
